FILE: rtl/calendar_date_advance_assert.svh
// Assertion macros for the calendar date block.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef CALENDAR_DATE_ADVANCE_ASSERT_SVH
`define CALENDAR_DATE_ADVANCE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Plain property, checked at every clock edge outside reset.
`define CDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("calendar_date_advance: check failed");

// Same-cycle implication.
`define CDA_ASSERT_IMPL(lbl, ante, cons) \
  `CDA_ASSERT(lbl, (ante) |-> (cons))

`else

`define CDA_ASSERT(lbl, prop)
`define CDA_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

FILE: rtl/calda_pkg.sv
// Shared types, constants and the month length function for the calendar date block.
// No dependencies.
package calda_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 16;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

  localparam logic OP_SET     = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_RESP
  } state_e;

  // Julian rule: February has 29 days in every year divisible by four.
  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic [YEAR_W-1:0]  y);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MONTH_FEB:                                 len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/calendar_date_advance.sv
// Calendar date keeper: stored date, set with validation, advance by a day count.
// Depends on calda_pkg and calendar_date_advance_assert.svh.

// Holds one date (Julian leap rule) and a valid flag. Each input word is a
// command: tuser 0 sets the date from tdata after checking year 1..YEAR_LIMIT,
// month 1..12 and day 1..month length; tuser 1 adds days_to_add to the stored
// date. Every command returns one output word with the stored date after the
// command and an accepted flag; a rejected command leaves the date as it was.
// An advance with no valid date, or one that would carry the year past
// YEAR_LIMIT, is rejected. Timing: a set, or an advance with no valid date,
// passes from accept through the response state to the output register; an
// advance first runs in the advance state, since one subtract-and-compare unit
// steps through the calendar one month per cycle. Input is taken only while the
// sequencer is idle; a finished result waits in the output register, and a new
// word may be accepted while it does.
`include "calendar_date_advance_assert.svh"

module calendar_date_advance #(
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata, low bit up: set_year[13:0], set_month[3:0], set_day[4:0],
  //                    days_to_add[15:0], one zero pad bit
  input  logic [39:0] s_axis_tdata_i,
  // tuser: opcode (0 set, 1 advance)
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata, low bit up: cur_year[13:0], cur_month[3:0], cur_day[4:0], one zero pad bit
  output logic [23:0] m_axis_tdata_o,
  // tuser: accepted
  output logic        m_axis_tuser_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  import calda_pkg::*;

  localparam logic [YEAR_W:0] YearLimitExt = (YEAR_W + 1)'(YEAR_LIMIT);

  // Input word fields
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic [COUNT_W-1:0] in_count;

  assign in_year  = s_axis_tdata_i[13:0];
  assign in_month = s_axis_tdata_i[17:14];
  assign in_day   = s_axis_tdata_i[22:18];
  assign in_count = s_axis_tdata_i[38:23];

  state_e state_q, state_d;

  // Stored date
  logic [YEAR_W-1:0]  year_q,  year_d;
  logic [MONTH_W-1:0] month_q, month_d;
  logic [DAY_W-1:0]   day_q,   day_d;
  logic               date_valid_q, date_valid_d;

  // Working date and remaining count of the running advance
  logic [YEAR_W-1:0]  wy_q, wy_d;
  logic [MONTH_W-1:0] wm_q, wm_d;
  logic [DAY_W-1:0]   wd_q, wd_d;
  logic [COUNT_W-1:0] n_q,  n_d;
  logic               ok_q, ok_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [23:0]        out_data_q,  out_data_d;
  logic               out_ok_q,    out_ok_d;

  logic               out_free;
  logic               in_fire;
  logic               set_ok;
  logic [DAY_W-1:0]   room;
  logic [YEAR_W:0]    year_inc;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign set_ok = (in_year != '0) && ({1'b0, in_year} <= YearLimitExt) &&
                  (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC) &&
                  (in_day != '0) && (in_day <= days_in_month(in_month, in_year));

  // Shared step unit: days left in the working month, and the next year.
  assign room     = days_in_month(wm_q, wy_q) - wd_q;
  assign year_inc = {1'b0, wy_q} + (YEAR_W + 1)'(1);

  always_comb begin
    state_d      = state_q;
    year_d       = year_q;
    month_d      = month_q;
    day_d        = day_q;
    date_valid_d = date_valid_q;
    wy_d         = wy_q;
    wm_d         = wm_q;
    wd_d         = wd_q;
    n_d          = n_q;
    ok_d         = ok_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    out_ok_d     = out_ok_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i == OP_SET) begin
            ok_d    = set_ok;
            state_d = ST_RESP;
            if (set_ok) begin
              year_d       = in_year;
              month_d      = in_month;
              day_d        = in_day;
              date_valid_d = 1'b1;
            end
          end else begin
            wy_d = year_q;
            wm_d = month_q;
            wd_d = day_q;
            n_d  = in_count;
            if (date_valid_q) begin
              state_d = ST_ADV;
            end else begin
              ok_d    = 1'b0;
              state_d = ST_RESP;
            end
          end
        end
      end

      ST_ADV: begin
        if ({{(COUNT_W-DAY_W){1'b0}}, room} >= n_q) begin
          // Fits in the working month: commit.
          year_d  = wy_q;
          month_d = wm_q;
          day_d   = wd_q + n_q[DAY_W-1:0];
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end else begin
          n_d  = n_q - ({{(COUNT_W-DAY_W){1'b0}}, room} + COUNT_W'(1));
          wd_d = DAY_FIRST;
          if (wm_q == MONTH_DEC) begin
            wm_d = MONTH_JAN;
            if (year_inc > YearLimitExt) begin
              ok_d    = 1'b0;
              state_d = ST_RESP;
            end else begin
              wy_d = year_inc[YEAR_W-1:0];
            end
          end else begin
            wm_d = wm_q + MONTH_W'(1);
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, day_q, month_q, year_q};
          out_ok_d    = ok_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control and stored date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      year_q       <= '0;
      month_q      <= '0;
      day_q        <= '0;
      date_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      year_q       <= year_d;
      month_q      <= month_d;
      day_q        <= day_d;
      date_valid_q <= date_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    wy_q       <= wy_d;
    wm_q       <= wm_d;
    wd_q       <= wd_d;
    n_q        <= n_d;
    ok_q       <= ok_d;
    out_data_q <= out_data_d;
    out_ok_q   <= out_ok_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ok_q;

  // A valid stored date always has a real month and an in-range day.
  `CDA_ASSERT_IMPL(a_month_range, date_valid_q, (month_q >= MONTH_JAN) && (month_q <= MONTH_DEC))
  `CDA_ASSERT_IMPL(a_day_range, date_valid_q,
                   (day_q != '0) && (day_q <= days_in_month(month_q, year_q)))
  // Nothing is stored before the first accepted set.
  `CDA_ASSERT_IMPL(a_no_date, !date_valid_q, (month_q == '0) && (year_q == '0))

endmodule
